[src/life_generation_row_stencil_unit_defines.svh]
// ----------------------------------------------------------------------------
// life generation row stencil unit: assertion macros
// shared concurrent check forms for the stencil blocks
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STENCIL_UNIT_DEFINES_SVH
`define LIFE_GENERATION_ROW_STENCIL_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define LGRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define LGRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lgrs_pkg.sv]
// ----------------------------------------------------------------------------
// lgrs_pkg
// types, constants and the life rule shared by the row stencil blocks
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int ROW_W      = 64;
    localparam int WIDTH_W    = 7;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // one column's view as seen by its neighbors
    typedef struct packed {
        logic upper;
        logic middle;
        logic row;
    } nbr_t;

    // row-wide control handed to every cell
    typedef struct packed {
        logic advance;
        logic last;
        logic held;
    } cell_ctrl_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_row;
        logic             frame_end;
    } result_t;

    // b3/s23 on eight neighbor bits
    function automatic logic life_next(input logic alive, input logic [7:0] nbrs);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(nbrs[i]);
        end
        return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && alive);
    endfunction

endpackage

[src/lgrs_cell.sv]
// ----------------------------------------------------------------------------
// lgrs_cell
// one grid column: holds upper and middle bits, evaluates both results
// ----------------------------------------------------------------------------
module lgrs_cell
    import lgrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       live,
    input  logic       row_bit,
    input  nbr_t       left,
    input  nbr_t       right,
    output nbr_t       own,
    output logic       mid_bit,
    output logic       last_bit
);

    logic upper_reg;
    logic upper_next;
    logic middle_reg;
    logic middle_next;
    logic [7:0] mid_nbrs;
    logic [7:0] last_nbrs;

    assign own.upper  = upper_reg & live;
    assign own.middle = middle_reg & live;
    assign own.row    = row_bit & live;

    assign mid_nbrs = {left.upper, own.upper, right.upper,
                       left.middle, right.middle,
                       left.row, own.row, right.row};

    // bottom row flush: below is dead, above only if a row is held
    assign last_nbrs = {left.middle & ctrl.held, own.middle & ctrl.held,
                        right.middle & ctrl.held, left.row, right.row, 3'b000};

    assign mid_bit  = life_next(own.middle, mid_nbrs) & live;
    assign last_bit = life_next(own.row, last_nbrs) & live;

    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (ctrl.advance)
        begin
            upper_next  = (ctrl.last || !ctrl.held) ? 1'b0 : middle_reg;
            middle_next = ctrl.last ? 1'b0 : own.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
        end
    end

endmodule

[src/lgrs_out_fifo.sv]
// ----------------------------------------------------------------------------
// lgrs_out_fifo
// result queue taking up to two words per cycle, draining one while out_ready is high
// ----------------------------------------------------------------------------
`include "life_generation_row_stencil_unit_defines.svh"

module lgrs_out_fifo
    import lgrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_a,
    input  result_t data_a,
    input  logic    push_b,
    input  result_t data_b,
    output logic    room_two,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t                mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic [OUT_PTR_W-1:0]   wr_idx_b;
    logic [1:0]             push_cnt;
    logic                   pop;

    assign pop      = out_valid && out_ready;
    assign push_cnt = {1'b0, push_a} + {1'b0, push_b};
    assign wr_idx_b = push_a ? wr_ptr_reg + OUT_PTR_W'(1) : wr_ptr_reg;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign room_two  = (count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            mem[wr_idx_b] <= data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LGRS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= OUT_CNT_W'(OUT_DEPTH), "result queue count out of range")
    `LGRS_ASSERT_SAME(a_no_overflow, clk, rst_n, push_cnt != 2'd0, (OUT_CNT_W+1)'(count_reg) + (OUT_CNT_W+1)'(push_cnt) <= (OUT_CNT_W+1)'(OUT_DEPTH), "result queue overflow")
    `LGRS_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && (push_cnt == 2'd0), count_reg == $past(count_reg) - OUT_CNT_W'(1), "queue count did not drop on pop")

endmodule

[src/life_generation_row_stencil_unit.sv]
// ----------------------------------------------------------------------------
// life_generation_row_stencil_unit
// one life generation (b3/s23) over a grid streamed in row by row
// ----------------------------------------------------------------------------
// input words carry one row (row_cells, bit c = column c) with first_row and
// last_row marks. each accepted row but the first of a frame yields the next
// generation of the row before it; the bottom row also yields its own, tagged
// frame_end. the row_width channel sets the live column count; the user must
// write it only while the block is idle, which the block does not enforce.
// columns at or beyond it are dead and come out as zero. a row is taken every
// cycle while in_ready is high: one cell per column holds the two earlier rows
// and all columns evaluate together, so a result word enters the output queue
// at the edge that accepts its row. the queue holds four words and drains one
// per cycle while out_ready is high; in_ready drops while it holds more than
// two, which never happens while the receiver keeps out_ready high, so rows
// then flow one per cycle; a stalled receiver backs up into in_ready.
// reset (rst_n low) clears the held rows, empties the queue and sets
// row_width to 64.
// ----------------------------------------------------------------------------
`include "life_generation_row_stencil_unit_defines.svh"

module life_generation_row_stencil_unit
    import lgrs_pkg::*;
#(
    parameter int ROW_CELLS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] row_width,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ROW_W-1:0]   row_cells,
    input  logic               first_row,
    input  logic               last_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ROW_W-1:0]   next_row,
    output logic               frame_end
);

    logic [WIDTH_W-1:0]   row_width_reg;
    logic [WIDTH_W-1:0]   row_width_next;
    logic                 held_reg;
    logic                 held_next;
    logic                 accept;
    logic                 room_two;
    cell_ctrl_t           ctrl;
    logic [ROW_CELLS-1:0] live;
    logic [ROW_CELLS-1:0] mid_vec;
    logic [ROW_CELLS-1:0] last_vec;
    nbr_t                 own [ROW_CELLS];
    result_t              res_mid;
    result_t              res_last;
    result_t              out_word;

    assign cfg_ready = 1'b1;
    assign in_ready  = room_two;
    assign accept    = in_valid && in_ready;

    // a first-row mark drops whatever the open frame held
    assign ctrl.advance = accept;
    assign ctrl.last    = last_row;
    assign ctrl.held    = held_reg && !first_row;

    always_comb
    begin
        for (int c = 0; c < ROW_CELLS; c++)
        begin
            live[c] = (WIDTH_W'(c) < row_width_reg);
        end
    end

    for (genvar c = 0; c < ROW_CELLS; c++)
    begin : g_cell
        nbr_t left_n;
        nbr_t right_n;
        if (c == 0)
        begin : g_left_edge
            assign left_n = '0;
        end
        else
        begin : g_left
            assign left_n = own[c-1];
        end
        if (c == ROW_CELLS - 1)
        begin : g_right_edge
            assign right_n = '0;
        end
        else
        begin : g_right
            assign right_n = own[c+1];
        end

        lgrs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .live     (live[c]),
            .row_bit  (row_cells[c]),
            .left     (left_n),
            .right    (right_n),
            .own      (own[c]),
            .mid_bit  (mid_vec[c]),
            .last_bit (last_vec[c])
        );
    end

    assign res_mid.next_row   = ROW_W'(mid_vec);
    assign res_mid.frame_end  = 1'b0;
    assign res_last.next_row  = ROW_W'(last_vec);
    assign res_last.frame_end = 1'b1;

    lgrs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (accept && ctrl.held),
        .data_a    (res_mid),
        .push_b    (accept && last_row),
        .data_b    (res_last),
        .room_two  (room_two),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_word)
    );

    assign next_row  = out_word.next_row;
    assign frame_end = out_word.frame_end;

    always_comb
    begin
        row_width_next = row_width_reg;
        held_next      = held_reg;
        if (cfg_valid && cfg_ready)
        begin
            row_width_next = row_width;
        end
        if (accept)
        begin
            held_next = !last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= WIDTH_RESET;
            held_reg      <= 1'b0;
        end
        else
        begin
            row_width_reg <= row_width_next;
            held_reg      <= held_next;
        end
    end

    `LGRS_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && last_row, !held_reg, "bottom row left a row held")
    `LGRS_ASSERT_NEXT(a_row_held, clk, rst_n, accept && !last_row, held_reg, "accepted row not held")
    `LGRS_ASSERT_SAME(a_dead_cols, clk, rst_n, out_valid, (next_row & ~ROW_W'(live)) == '0, "live bit beyond row width")

endmodule
